// ===== rtl/wba_pkg.sv =====
// ----------------------------------------------------------------------------
// wba_pkg
// Shared types and constants for the windowed bucket accumulator.
// ----------------------------------------------------------------------------
package wba_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CNT_W   = 40;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX           = {CNT_W{1'b1}};
  localparam logic [TIME_W-1:0] PERIOD_DEFAULT_MS = TIME_W'(1000);
  localparam logic [TIME_W-1:0] WINDOW_DEFAULT_MS = TIME_W'(60000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD = 2'd0,
    CFG_WINDOW = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DROP_RD,
    ST_DROP,
    ST_OPEN,
    ST_EV_RD,
    ST_EV_CHK,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  sum;
  } bucket_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
  endfunction

endpackage

// ===== rtl/wba_in_if.sv =====
// ----------------------------------------------------------------------------
// wba_in_if
// Sample channel: arrival time and fixed-point value.
// ----------------------------------------------------------------------------
interface wba_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        sample_time_ms;
  logic signed [31:0] sample_value;

  modport source (output valid, output sample_time_ms, output sample_value, input ready);
  modport sink   (input valid, input sample_time_ms, input sample_value, output ready);
endinterface

// ===== rtl/wba_out_if.sv =====
// ----------------------------------------------------------------------------
// wba_out_if
// Result channel: lifetime and window totals, ring occupancy.
// ----------------------------------------------------------------------------
interface wba_out_if #(
  parameter int unsigned HELD_W = 7
);
  logic               valid;
  logic               ready;
  logic [39:0]        lifetime_count;
  logic signed [63:0] lifetime_sum;
  logic [39:0]        window_count;
  logic signed [63:0] window_sum;
  logic [HELD_W-1:0]  buckets_in_use;

  modport source (output valid, output lifetime_count, output lifetime_sum,
                  output window_count, output window_sum, output buckets_in_use,
                  input ready);
  modport sink   (input valid, input lifetime_count, input lifetime_sum,
                  input window_count, input window_sum, input buckets_in_use,
                  output ready);
endinterface

// ===== rtl/wba_ram.sv =====
// ----------------------------------------------------------------------------
// wba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/wba_rem_div.sv =====
// ----------------------------------------------------------------------------
// wba_rem_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module wba_rem_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);
  import wba_pkg::*;

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] shf_q, shf_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    shf_d  = shf_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    done_o = 1'b0;
    trial  = {rem_q[31:0], shf_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      shf_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, dvs_q}) ? trial - {1'b0, dvs_q} : trial;
      shf_d = {shf_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  // remainder is final in the cycle done is raised
  assign rem_o = rem_d[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end
endmodule

// ===== rtl/windowed_bucket_accumulator.sv =====
// ----------------------------------------------------------------------------
// windowed_bucket_accumulator
// Sorts timestamped samples into period-aligned buckets held in a ring and
// reports lifetime and sliding-window count and sum for every sample.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  sample_i  in   valid/ready    sample_time_ms, sample_value
//  result_o  out  valid/ready    lifetime/window count and sum, buckets_in_use
//  cfg       in   cfg_we_i       cfg_index_i, cfg_data_i
//
// a sample that stays in the newest bucket goes straight to update; one that
// opens a bucket waits for the remainder unit, reads and drops the oldest entry
// of a full ring, writes the ring and, when the window applies, reads the oldest
// buckets one at a time and evicts them until one lies in the window or only one
// is left. reset leaves one bucket starting at time 0; no clearing pass. a
// stalled result holds in the output register while the next word enters.
// ----------------------------------------------------------------------------
module windowed_bucket_accumulator #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wba_in_if.sink                         sample_i,
  wba_out_if.source                      result_o
);
  import wba_pkg::*;

  localparam int unsigned SlotW = $clog2(RING_DEPTH);
  localparam int unsigned HeldW = $clog2(RING_DEPTH + 1);

  state_e state_q, state_d;

  logic [TIME_W-1:0] period_q, window_q;
  logic [TIME_W-1:0] now_q, now_d;
  logic [SUM_W-1:0]  val_q, val_d;
  logic [TIME_W-1:0] new_start_q, new_start_d;

  // newest bucket lives in registers, closed buckets in the ring
  bucket_t           newest_q, newest_d;
  logic [SlotW-1:0]  oldest_q, oldest_d, newest_slot_q, newest_slot_d;
  logic [HeldW-1:0]  held_q, held_d;
  logic [CNT_W-1:0]  tot_cnt_q, tot_cnt_d, win_cnt_q, win_cnt_d;
  logic [SUM_W-1:0]  tot_sum_q, tot_sum_d, win_sum_q, win_sum_d;

  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  out_tot_cnt_q, out_tot_cnt_d, out_win_cnt_q, out_win_cnt_d;
  logic [SUM_W-1:0]  out_tot_sum_q, out_tot_sum_d, out_win_sum_q, out_win_sum_d;
  logic [HeldW-1:0]  out_held_q, out_held_d;

  logic              ram_we;
  bucket_t           ram_rdata;
  logic              div_start, div_done;
  logic [31:0]       div_rem;
  logic [TIME_W-1:0] dt;
  logic [TIME_W-1:0] limit;
  logic              take;

  wba_ram #(.WIDTH($bits(bucket_t)), .DEPTH(RING_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (newest_slot_q),
    .wdata_i (newest_q),
    .raddr_i (oldest_q),
    .rdata_o (ram_rdata)
  );

  wba_rem_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dt),
    .divisor_i  (period_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    next_slot = (s == SlotW'(RING_DEPTH - 1)) ? '0 : s + SlotW'(1);
  endfunction

  assign sample_i.ready = (state_q == ST_IDLE);
  assign take           = sample_i.valid && sample_i.ready;
  assign dt    = (sample_i.sample_time_ms >= newest_q.start) ?
                 sample_i.sample_time_ms - newest_q.start : '0;
  assign limit = now_q - window_q;

  always_comb begin
    state_d       = state_q;
    now_d         = now_q;
    val_d         = val_q;
    new_start_d   = new_start_q;
    newest_d      = newest_q;
    oldest_d      = oldest_q;
    newest_slot_d = newest_slot_q;
    held_d        = held_q;
    tot_cnt_d     = tot_cnt_q;
    tot_sum_d     = tot_sum_q;
    win_cnt_d     = win_cnt_q;
    win_sum_d     = win_sum_q;
    out_valid_d   = out_valid_q && !result_o.ready;
    out_tot_cnt_d = out_tot_cnt_q;
    out_tot_sum_d = out_tot_sum_q;
    out_win_cnt_d = out_win_cnt_q;
    out_win_sum_d = out_win_sum_q;
    out_held_d    = out_held_q;
    ram_we        = 1'b0;
    div_start     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (take) begin
          now_d = sample_i.sample_time_ms;
          val_d = SUM_W'(sample_i.sample_value);
          if (period_q != '0 && dt > period_q) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // start + whole periods equals now minus the remainder
          new_start_d = now_q - div_rem;
          state_d     = (held_q >= HeldW'(RING_DEPTH)) ? ST_DROP_RD : ST_OPEN;
        end
      end
      ST_DROP_RD: state_d = ST_DROP;
      ST_DROP: begin
        win_cnt_d = (win_cnt_q > ram_rdata.count) ? win_cnt_q - ram_rdata.count : '0;
        win_sum_d = win_sum_q - ram_rdata.sum;
        oldest_d  = next_slot(oldest_q);
        held_d    = held_q - HeldW'(1);
        state_d   = ST_OPEN;
      end
      ST_OPEN: begin
        ram_we         = 1'b1;
        newest_slot_d  = next_slot(newest_slot_q);
        newest_d.start = new_start_q;
        newest_d.count = '0;
        newest_d.sum   = '0;
        held_d         = held_q + HeldW'(1);
        state_d = (window_q != '0 && now_q >= window_q) ? ST_EV_RD : ST_UPDATE;
      end
      ST_EV_RD: state_d = ST_EV_CHK;
      ST_EV_CHK: begin
        if (ram_rdata.start < limit) begin
          win_cnt_d = (win_cnt_q > ram_rdata.count) ? win_cnt_q - ram_rdata.count : '0;
          win_sum_d = win_sum_q - ram_rdata.sum;
          oldest_d  = next_slot(oldest_q);
          held_d    = held_q - HeldW'(1);
          state_d   = (held_q > HeldW'(2)) ? ST_EV_RD : ST_UPDATE;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid_q || result_o.ready) begin
          newest_d.count = sat_inc(newest_q.count);
          newest_d.sum   = newest_q.sum + val_q;
          win_cnt_d      = sat_inc(win_cnt_q);
          win_sum_d      = win_sum_q + val_q;
          tot_cnt_d      = sat_inc(tot_cnt_q);
          tot_sum_d      = tot_sum_q + val_q;
          out_valid_d    = 1'b1;
          out_tot_cnt_d  = tot_cnt_d;
          out_tot_sum_d  = tot_sum_d;
          out_win_cnt_d  = win_cnt_d;
          out_win_sum_d  = win_sum_d;
          out_held_d     = held_q;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      period_q      <= PERIOD_DEFAULT_MS;
      window_q      <= WINDOW_DEFAULT_MS;
      newest_q      <= '0;
      oldest_q      <= '0;
      newest_slot_q <= '0;
      held_q        <= HeldW'(1);
      tot_cnt_q     <= '0;
      tot_sum_q     <= '0;
      win_cnt_q     <= '0;
      win_sum_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      newest_q      <= newest_d;
      oldest_q      <= oldest_d;
      newest_slot_q <= newest_slot_d;
      held_q        <= held_d;
      tot_cnt_q     <= tot_cnt_d;
      tot_sum_q     <= tot_sum_d;
      win_cnt_q     <= win_cnt_d;
      win_sum_q     <= win_sum_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PERIOD: period_q <= cfg_data_i;
          CFG_WINDOW: window_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q         <= now_d;
    val_q         <= val_d;
    new_start_q   <= new_start_d;
    out_tot_cnt_q <= out_tot_cnt_d;
    out_tot_sum_q <= out_tot_sum_d;
    out_win_cnt_q <= out_win_cnt_d;
    out_win_sum_q <= out_win_sum_d;
    out_held_q    <= out_held_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.lifetime_count = out_tot_cnt_q;
  assign result_o.lifetime_sum   = out_tot_sum_q;
  assign result_o.window_count   = out_win_cnt_q;
  assign result_o.window_sum     = out_win_sum_q;
  assign result_o.buckets_in_use = out_held_q;
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timestamped samples and register writes into the windowed bucket
// accumulator and checks every result word against a local bucket-ring model.
// ----------------------------------------------------------------------------
module testbench;
  import wba_pkg::*;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned LIMIT_CYC = 1500000;
  localparam int unsigned N_RANDOM  = 1600;
  localparam int unsigned EXP_DEPTH = 16;

  typedef struct packed {
    logic [CNT_W-1:0] lt_cnt;
    logic [SUM_W-1:0] lt_sum;
    logic [CNT_W-1:0] win_cnt;
    logic [SUM_W-1:0] win_sum;
    logic [6:0]       held;
  } totals_t;

  typedef struct {
    logic [31:0] t;
    logic [31:0] v;
    bit          has_exp;
    totals_t     exp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  wba_in_if  smp ();
  wba_out_if res ();

  windowed_bucket_accumulator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .sample_i(smp.sink), .result_o(res.source)
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [31:0] period_ms, window_ms;
  logic [31:0] b_start [DEPTH];
  logic [CNT_W-1:0] b_cnt [DEPTH];
  logic [SUM_W-1:0] b_sum [DEPTH];
  int unsigned head_slot, tail_slot, n_held;
  logic [CNT_W-1:0] all_cnt, win_cnt;
  logic [SUM_W-1:0] all_sum, win_sum;

  // expected words in flight, written by the driver and read by the checker
  totals_t exp_fifo [EXP_DEPTH];
  int unsigned exp_wr = 0, exp_rd = 0;
  int unsigned errors = 0;
  int unsigned words_seen = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  logic [31:0] now_ms = 0;

  function automatic logic [CNT_W-1:0] cnt_plus(logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic void model_reset();
    period_ms = PERIOD_DEFAULT_MS;
    window_ms = WINDOW_DEFAULT_MS;
    b_start[0] = '0; b_cnt[0] = '0; b_sum[0] = '0;
    head_slot = 0; tail_slot = 0; n_held = 1;
    all_cnt = '0; all_sum = '0; win_cnt = '0; win_sum = '0;
  endfunction

  function automatic void drop_tail();
    win_cnt = (win_cnt > b_cnt[tail_slot]) ? win_cnt - b_cnt[tail_slot] : '0;
    win_sum = win_sum - b_sum[tail_slot];
    tail_slot = (tail_slot + 1) % DEPTH;
    n_held--;
  endfunction

  function automatic totals_t accumulate(logic [31:0] t, logic [31:0] v);
    logic [31:0] st, dt, lim;
    logic [63:0] sv, steps;
    totals_t r;
    st = b_start[head_slot];
    dt = (t >= st) ? t - st : '0;
    sv = {{32{v[31]}}, v};
    if (period_ms != 0 && dt > period_ms) begin
      steps = dt / period_ms;
      if (n_held >= DEPTH) drop_tail();
      head_slot = (head_slot + 1) % DEPTH;
      b_start[head_slot] = 32'(64'(st) + steps * 64'(period_ms));
      b_cnt[head_slot] = '0;
      b_sum[head_slot] = '0;
      n_held++;
      if (window_ms != 0 && t >= window_ms) begin
        lim = t - window_ms;
        while (n_held > 1 && b_start[tail_slot] < lim) drop_tail();
      end
    end
    b_cnt[head_slot] = cnt_plus(b_cnt[head_slot]);
    b_sum[head_slot] = b_sum[head_slot] + sv;
    win_cnt = cnt_plus(win_cnt);
    win_sum = win_sum + sv;
    all_cnt = cnt_plus(all_cnt);
    all_sum = all_sum + sv;
    r.lt_cnt = all_cnt; r.lt_sum = all_sum;
    r.win_cnt = win_cnt; r.win_sum = win_sum;
    r.held = 7'(n_held);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("word %0d: %s got %0h want %0h", words_seen, what, got, want);
    errors++;
  endtask

  // receiver and checker
  initial res.ready = 1'b0;
  always @(posedge clk_i) begin
    totals_t e;
    cycles <= cycles + 1;
    if (rst_ni && res.valid && res.ready) begin
      words_seen++;
      if (exp_wr == exp_rd) begin
        report_mismatch("unexpected word", 64'(res.lifetime_count), 64'd0);
      end else begin
        e = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (res.lifetime_count !== e.lt_cnt)
          report_mismatch("lifetime_count", 64'(res.lifetime_count), 64'(e.lt_cnt));
        if (res.lifetime_sum !== e.lt_sum)
          report_mismatch("lifetime_sum", res.lifetime_sum, e.lt_sum);
        if (res.window_count !== e.win_cnt)
          report_mismatch("window_count", 64'(res.window_count), 64'(e.win_cnt));
        if (res.window_sum !== e.win_sum)
          report_mismatch("window_sum", res.window_sum, e.win_sum);
        if (res.buckets_in_use !== e.held)
          report_mismatch("buckets_in_use", 64'(res.buckets_in_use), 64'(e.held));
      end
    end
    res.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("windowed_bucket_accumulator: mismatch");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PERIOD) period_ms = val;
    else if (idx == CFG_WINDOW) window_ms = val;
  endtask

  // unknown index, block must ignore it
  task automatic write_bad_index();
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= CFG_IDX_W'(3); cfg_data_i <= $urandom;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one sample word; expectation queued once accepted
  // valid stays high after acceptance so back-to-back words need no gap
  task automatic send_sample(logic [31:0] t, logic [31:0] v, bit check_fixed = 0,
                             totals_t fixed = '0);
    totals_t p;
    if ($urandom_range(99) < send_idle_pct) begin
      smp.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    smp.valid <= 1'b1; smp.sample_time_ms <= t; smp.sample_value <= v;
    do @(posedge clk_i); while (!smp.ready);
    p = accumulate(t, v);
    if (check_fixed && p !== fixed) begin
      $display("typed expectation disagrees for time %0h", t);
      errors++;
    end
    exp_fifo[exp_wr % EXP_DEPTH] = p;
    exp_wr++;
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic totals_t tot(logic [39:0] lc, logic [63:0] ls, logic [39:0] wc,
                                  logic [63:0] ws, logic [6:0] h);
    totals_t r;
    r.lt_cnt = lc; r.lt_sum = ls; r.win_cnt = wc; r.win_sum = ws; r.held = h;
    return r;
  endfunction

  // random phase; step mostly small so buckets open and evict often
  task automatic random_phase(int unsigned n, int unsigned sp, int unsigned rp);
    logic [31:0] step, v;
    send_idle_pct = sp; recv_idle_pct = rp;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: step = 0;
        1: step = $urandom_range(100000);
        2: step = -$urandom_range(500);
        default: step = $urandom_range(3 * period_ms + 3);
      endcase
      if (period_ms > 32'd100000 && $urandom_range(3) == 0) step = $urandom;
      now_ms = now_ms + step;
      case ($urandom_range(5))
        0: v = 32'h7fff_ffff;
        1: v = 32'h8000_0000;
        default: v = $urandom;
      endcase
      send_sample(now_ms, v);
    end
    drain();
  endtask

  stim_row_t rows [$];

  initial begin
    stim_row_t r;
    smp.valid = 1'b0; smp.sample_time_ms = '0; smp.sample_value = '0;
    model_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; typed rows are read off defaults after reset
    r = '{32'd0, 32'h7fff_ffff, 1, tot(1, 64'h7fff_ffff, 1, 64'h7fff_ffff, 1)};
    rows.push_back(r);
    r = '{32'd1000, 32'h8000_0000, 1, tot(2, -64'sd1, 2, -64'sd1, 1)};
    rows.push_back(r);
    r = '{32'd1001, 32'h0001_0000, 1,
          tot(3, 64'h0_ffff, 3, 64'h0_ffff, 2)};
    rows.push_back(r);
    r = '{32'd500, 32'hffff_0000, 0, '0};    // time going backwards
    rows.push_back(r);
    r = '{32'd5500, 32'd7, 0, '0};
    rows.push_back(r);
    r = '{32'd70000, 32'd9, 0, '0};           // long jump evicts old buckets
    rows.push_back(r);
    r = '{32'hffff_ffff, 32'h8000_0000, 0, '0};
    rows.push_back(r);
    foreach (rows[i]) send_sample(rows[i].t, rows[i].v, rows[i].has_exp, rows[i].exp);
    drain();

    write_bad_index();
    // period zero: one bucket forever
    write_reg(CFG_PERIOD, 32'd0);
    write_reg(CFG_WINDOW, 32'd0);
    now_ms = 0;
    random_phase(60, 0, 0);

    // small period, no eviction: ring fills and drops its oldest
    write_reg(CFG_PERIOD, 32'd1);
    now_ms = 0;
    for (int i = 0; i < 80; i++) send_sample(32'(2 * i + 2), $urandom);
    drain();

    write_reg(CFG_PERIOD, 32'hffff_ffff);
    write_reg(CFG_WINDOW, 32'hffff_ffff);
    send_sample(32'hffff_ffff, 32'd3);
    send_sample(32'd0, 32'd4);
    drain();

    write_reg(CFG_PERIOD, 32'd10);
    write_reg(CFG_WINDOW, 32'd200);
    now_ms = 0;
    random_phase(N_RANDOM / 3, 36, 82);
    write_reg(CFG_PERIOD, 32'd7);
    write_reg(CFG_WINDOW, 32'd40);
    random_phase(N_RANDOM / 3, 82, 36);
    write_reg(CFG_PERIOD, PERIOD_DEFAULT_MS);
    write_reg(CFG_WINDOW, WINDOW_DEFAULT_MS);
    random_phase(N_RANDOM / 3, 0, 0);

    $display("checked %0d result words over directed rows, ring wrap, extreme", words_seen);
    $display("registers and three random phases with varied back-pressure");
    if (errors == 0) begin
      $display("windowed_bucket_accumulator: match");
    end else begin
      $display("windowed_bucket_accumulator: mismatch");
    end
    $finish;
  end

endmodule
